@@ rtl/hrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hrgb_pkg
// Shared types, constants and 8-bit scaling helpers for the rainbow HSV to RGB
// converter.
// ----------------------------------------------------------------------------
package hrgb_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // Ramp multipliers: one third and two thirds of full scale
    localparam logic [CHAN_W-1:0] THIRD      = 8'(256 / 3);
    localparam logic [CHAN_W-1:0] TWO_THIRDS = 8'((256 * 2) / 3);
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_YELLOW_STRONG = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GREEN_HALVE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GREEN_SCALE   = 2'd2;

    // Rainbow sections picked by the top three hue bits
    typedef enum logic [2:0] {
        SEC_RED    = 3'd0,
        SEC_ORANGE = 3'd1,
        SEC_YELLOW = 3'd2,
        SEC_GREEN  = 3'd3,
        SEC_AQUA   = 3'd4,
        SEC_BLUE   = 3'd5,
        SEC_PURPLE = 3'd6,
        SEC_PINK   = 3'd7
    } section_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    // (a * b) >> 8
    function automatic logic [CHAN_W-1:0] mul8(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
        logic [2*CHAN_W-1:0] prod;
        prod = a * b;
        return prod[2*CHAN_W-1:CHAN_W];
    endfunction

    // (a * b) >> 8, plus one when both operands are nonzero
    function automatic logic [CHAN_W-1:0] mul8_video(input logic [CHAN_W-1:0] a,
                                                     input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] base;
        logic              bump;
        base = mul8(a, b);
        bump = (a != '0) && (b != '0);
        return base + CHAN_W'(bump);
    endfunction

endpackage

@@ rtl/hsv_rainbow_to_rgb_unit.sv @@
// ----------------------------------------------------------------------------
// hsv_rainbow_to_rgb_unit
// Converts a stream of 8-bit HSV pixels to 8-bit RGB with an eight-section
// rainbow hue map. One pixel enters per clock while the pipeline has room;
// each result passes through four register stages, each holding one rank
// of 8x8 multipliers: ramp and squaring terms, hue section mapping with the
// green scale, saturation blend, and brightness scaling. A stall on the
// output side fills pipeline bubbles first, so the input keeps taking beats
// while a finished result waits. Configuration registers are sampled live
// by the stages and must only be written while the pipeline is empty.
// ----------------------------------------------------------------------------
module hsv_rainbow_to_rgb_unit
    import hrgb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // hue [7:0], saturation [15:8], brightness [23:16]
    // Pixel output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata    // red [7:0], green [15:8], blue [23:16]
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic              yellow_strong_reg;
    logic              green_halve_reg;
    logic [CHAN_W-1:0] green_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yellow_strong_reg <= 1'b0;
            green_halve_reg   <= 1'b0;
            green_scale_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_YELLOW_STRONG: yellow_strong_reg <= cfg_wdata[0];
                CFG_GREEN_HALVE:   green_halve_reg   <= cfg_wdata[0];
                CFG_GREEN_SCALE:   green_scale_reg   <= cfg_wdata;
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when its upstream holds a beat
    // and it is empty or itself advancing.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;
    logic s1_load, s2_load, s3_load, s4_load;

    assign s4_ready = !s4_valid_reg || m_tready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    assign s1_load = s_tvalid && s1_ready;
    assign s2_load = s1_valid_reg && s2_ready;
    assign s3_load = s2_valid_reg && s3_ready;
    assign s4_load = s3_valid_reg && s4_ready;

    assign s_tready = s1_ready;
    assign m_tvalid = s4_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready) begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: hue ramps, desaturation term, squared brightness
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0] in_hue, in_sat, in_val;
    logic [CHAN_W-1:0] s1_ramp_next, s1_desat_next;

    logic [2:0]        s1_section_reg;
    logic [CHAN_W-1:0] s1_ramp_reg, s1_one3_reg, s1_two3_reg;
    logic [CHAN_W-1:0] s1_desat_reg, s1_vsq_reg;
    logic              s1_sat_full_reg, s1_sat_zero_reg, s1_val_full_reg;

    assign in_hue = s_tdata[7:0];
    assign in_sat = s_tdata[15:8];
    assign in_val = s_tdata[23:16];

    assign s1_ramp_next  = {in_hue[4:0], 3'b000};
    assign s1_desat_next = mul8_video(CHAN_MAX - in_sat, CHAN_MAX - in_sat);

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_section_reg  <= in_hue[7:5];
            s1_ramp_reg     <= s1_ramp_next;
            s1_one3_reg     <= mul8(s1_ramp_next, THIRD);
            s1_two3_reg     <= mul8(s1_ramp_next, TWO_THIRDS);
            s1_desat_reg    <= s1_desat_next;
            s1_vsq_reg      <= mul8_video(in_val, in_val);
            s1_sat_full_reg <= (in_sat == CHAN_MAX);
            s1_sat_zero_reg <= (in_sat == '0);
            s1_val_full_reg <= (in_val == CHAN_MAX);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: section mapping, green halving and green video scale
    // ------------------------------------------------------------------
    rgb_t              hue_rgb;
    logic [CHAN_W-1:0] green_halved;
    logic [CHAN_W-1:0] green_scaled;

    rgb_t              s2_rgb_reg;
    logic [CHAN_W-1:0] s2_desat_reg, s2_keep_reg, s2_vsq_reg;
    logic              s2_sat_full_reg, s2_sat_zero_reg, s2_val_full_reg;

    always_comb begin
        hue_rgb = '0;
        unique case (section_t'(s1_section_reg))
            SEC_RED: begin
                hue_rgb.red   = CHAN_MAX - s1_one3_reg;
                hue_rgb.green = s1_one3_reg;
            end
            SEC_ORANGE: begin
                if (yellow_strong_reg) begin
                    hue_rgb.red   = 8'd170 + s1_one3_reg;
                    hue_rgb.green = 8'd85 + s1_two3_reg;
                end else begin
                    hue_rgb.red   = 8'd171;
                    hue_rgb.green = 8'd85 + s1_one3_reg;
                end
            end
            SEC_YELLOW: begin
                if (yellow_strong_reg) begin
                    hue_rgb.red   = CHAN_MAX - s1_ramp_reg;
                    hue_rgb.green = CHAN_MAX;
                end else begin
                    hue_rgb.red   = 8'd171 - s1_two3_reg;
                    hue_rgb.green = 8'd170 + s1_one3_reg;
                end
            end
            SEC_GREEN: begin
                hue_rgb.green = CHAN_MAX - s1_one3_reg;
                hue_rgb.blue  = s1_one3_reg;
            end
            SEC_AQUA: begin
                hue_rgb.green = 8'd171 - s1_two3_reg;
                hue_rgb.blue  = 8'd85 + s1_two3_reg;
            end
            SEC_BLUE: begin
                hue_rgb.red  = s1_one3_reg;
                hue_rgb.blue = CHAN_MAX - s1_one3_reg;
            end
            SEC_PURPLE: begin
                hue_rgb.red  = 8'd85 + s1_one3_reg;
                hue_rgb.blue = 8'd171 - s1_one3_reg;
            end
            SEC_PINK: begin
                hue_rgb.red  = 8'd170 + s1_one3_reg;
                hue_rgb.blue = 8'd85 - s1_one3_reg;
            end
            default: hue_rgb = '0;
        endcase
    end

    assign green_halved = green_halve_reg ? {1'b0, hue_rgb.green[CHAN_W-1:1]} : hue_rgb.green;
    assign green_scaled = (green_scale_reg != '0) ? mul8_video(green_halved, green_scale_reg)
                                                  : green_halved;

    always_ff @(posedge aclk) begin
        if (s2_load) begin
            s2_rgb_reg.red   <= hue_rgb.red;
            s2_rgb_reg.green <= green_scaled;
            s2_rgb_reg.blue  <= hue_rgb.blue;
            s2_desat_reg     <= s1_desat_reg;
            s2_keep_reg      <= CHAN_MAX - s1_desat_reg;
            s2_vsq_reg       <= s1_vsq_reg;
            s2_sat_full_reg  <= s1_sat_full_reg;
            s2_sat_zero_reg  <= s1_sat_zero_reg;
            s2_val_full_reg  <= s1_val_full_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: saturation - hold full color, force white, or blend
    // toward the desaturation floor
    // ------------------------------------------------------------------
    rgb_t              sat_rgb;
    rgb_t              s3_rgb_reg;
    logic [CHAN_W-1:0] s3_vsq_reg;
    logic              s3_val_full_reg;

    always_comb begin
        if (s2_sat_full_reg) begin
            sat_rgb = s2_rgb_reg;
        end else if (s2_sat_zero_reg) begin
            sat_rgb = '{red: CHAN_MAX, green: CHAN_MAX, blue: CHAN_MAX};
        end else begin
            sat_rgb.red   = mul8(s2_rgb_reg.red,   s2_keep_reg) + s2_desat_reg;
            sat_rgb.green = mul8(s2_rgb_reg.green, s2_keep_reg) + s2_desat_reg;
            sat_rgb.blue  = mul8(s2_rgb_reg.blue,  s2_keep_reg) + s2_desat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_load) begin
            s3_rgb_reg      <= sat_rgb;
            s3_vsq_reg      <= s2_vsq_reg;
            s3_val_full_reg <= s2_val_full_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: brightness scale, output register. A zero squared
    // brightness multiplies every channel to black.
    // ------------------------------------------------------------------
    rgb_t val_rgb;
    rgb_t s4_rgb_reg;

    always_comb begin
        if (s3_val_full_reg) begin
            val_rgb = s3_rgb_reg;
        end else begin
            val_rgb.red   = mul8(s3_rgb_reg.red,   s3_vsq_reg);
            val_rgb.green = mul8(s3_rgb_reg.green, s3_vsq_reg);
            val_rgb.blue  = mul8(s3_rgb_reg.blue,  s3_vsq_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_load) begin
            s4_rgb_reg <= val_rgb;
        end
    end

    assign m_tdata = {s4_rgb_reg.blue, s4_rgb_reg.green, s4_rgb_reg.red};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    // A stage that cannot hand off its beat keeps it
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s2_ready) |=> s1_valid_reg)
        else $error("stage 1 beat lost under stall");

    // Zero saturation yields white ahead of the brightness stage
    a_white: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_load && s2_sat_zero_reg) |=>
            (s3_rgb_reg.red == CHAN_MAX && s3_rgb_reg.green == CHAN_MAX &&
             s3_rgb_reg.blue == CHAN_MAX))
        else $error("zero saturation did not give white");

    // Zero squared brightness yields a black output beat
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (s4_load && !s3_val_full_reg && s3_vsq_reg == '0) |=> (m_tdata == '0))
        else $error("zero brightness did not give black");
`endif

endmodule

@@ tb/sv/hsv_rainbow_to_rgb_unit_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_rainbow_to_rgb_unit_chk
// Passive scoreboard for the rainbow HSV to RGB converter. Tracks register
// writes, predicts the RGB beat for each accepted HSV beat and compares each
// output beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module hsv_rainbow_to_rgb_unit_chk
    import hrgb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [23:0]           s_tdata,   // hue [7:0], saturation [15:8], brightness [23:16]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,   // red [7:0], green [15:8], blue [23:16]
    output int                    pixels_due,
    output int                    mismatch_cnt
);

    logic              yellow_strong_q;
    logic              green_halve_q;
    logic [CHAN_W-1:0] green_gain_q;
    rgb_t              rgb_due[$];
    rgb_t              want;
    rgb_t              got;

    // (a * b) >> 8
    function automatic logic [7:0] frac8(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] p;
        p = a * b;
        return p[15:8];
    endfunction

    // Same, bumped by one unless an operand is zero
    function automatic logic [7:0] frac8_video(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] base;
        base = frac8(a, b);
        return (a != 8'd0 && b != 8'd0) ? base + 8'd1 : base;
    endfunction

    function automatic rgb_t rainbow_pixel(input logic [7:0] hue, input logic [7:0] sat,
                                           input logic [7:0] bri, input logic ys,
                                           input logic gh, input logic [7:0] gs);
        logic [7:0] ramp;
        logic [7:0] one3;
        logic [7:0] two3;
        logic [7:0] desat;
        logic [7:0] keep;
        logic [7:0] bri_sq;
        section_t   sec;
        rgb_t       px;
        ramp = {hue[4:0], 3'b000};
        one3 = frac8(ramp, THIRD);
        two3 = frac8(ramp, TWO_THIRDS);
        sec  = section_t'(hue[7:5]);
        px   = '0;
        case (sec)
            SEC_RED: begin
                px.red   = CHAN_MAX - one3;
                px.green = one3;
            end
            SEC_ORANGE: begin
                if (ys) begin
                    px.red   = 8'd170 + one3;
                    px.green = 8'd85 + two3;
                end else begin
                    px.red   = 8'd171;
                    px.green = 8'd85 + one3;
                end
            end
            SEC_YELLOW: begin
                if (ys) begin
                    px.red   = CHAN_MAX - ramp;
                    px.green = CHAN_MAX;
                end else begin
                    px.red   = 8'd171 - two3;
                    px.green = 8'd170 + one3;
                end
            end
            SEC_GREEN: begin
                px.green = CHAN_MAX - one3;
                px.blue  = one3;
            end
            SEC_AQUA: begin
                px.green = 8'd171 - two3;
                px.blue  = 8'd85 + two3;
            end
            SEC_BLUE: begin
                px.red  = one3;
                px.blue = CHAN_MAX - one3;
            end
            SEC_PURPLE: begin
                px.red  = 8'd85 + one3;
                px.blue = 8'd171 - one3;
            end
            default: begin
                px.red  = 8'd170 + one3;
                px.blue = 8'd85 - one3;
            end
        endcase

        if (gh)
            px.green = px.green >> 1;
        if (gs != 8'd0)
            px.green = frac8_video(px.green, gs);

        // Reduced saturation: zero gives white, otherwise pull toward white with a floor
        if (sat != CHAN_MAX) begin
            if (sat == 8'd0) begin
                px = '1;
            end else begin
                desat    = frac8_video(CHAN_MAX - sat, CHAN_MAX - sat);
                keep     = CHAN_MAX - desat;
                px.red   = frac8(px.red, keep) + desat;
                px.green = frac8(px.green, keep) + desat;
                px.blue  = frac8(px.blue, keep) + desat;
            end
        end

        // Brightness is squared first, then scales every channel
        if (bri != CHAN_MAX) begin
            bri_sq = frac8_video(bri, bri);
            if (bri_sq == 8'd0) begin
                px = '0;
            end else begin
                px.red   = frac8(px.red, bri_sq);
                px.green = frac8(px.green, bri_sq);
                px.blue  = frac8(px.blue, bri_sq);
            end
        end
        return px;
    endfunction

    task automatic check_chan(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            mismatch_cnt++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            yellow_strong_q = 1'b0;
            green_halve_q   = 1'b0;
            green_gain_q    = '0;
            rgb_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_YELLOW_STRONG: yellow_strong_q = cfg_wdata[0];
                    CFG_GREEN_HALVE:   green_halve_q   = cfg_wdata[0];
                    CFG_GREEN_SCALE:   green_gain_q    = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                rgb_due.push_back(rainbow_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                                                yellow_strong_q, green_halve_q, green_gain_q));
            if (m_tvalid && m_tready) begin
                got.red   = m_tdata[7:0];
                got.green = m_tdata[15:8];
                got.blue  = m_tdata[23:16];
                if (rgb_due.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t ns: unexpected beat, expected none, actual %h", $time,
                             m_tdata);
                end else begin
                    want = rgb_due.pop_front();
                    check_chan("red", want.red, got.red);
                    check_chan("green", want.green, got.green);
                    check_chan("blue", want.blue, got.blue);
                end
            end
        end
        pixels_due = rgb_due.size();
    end

endmodule

@@ tb/sv/hsv_rainbow_to_rgb_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_rainbow_to_rgb_unit_tb
// Stimulus and verdict for the rainbow HSV to RGB converter. Runs a directed
// sweep of hue sections and level extremes, then random pixels under several
// register settings, with bursty input and a stalling output; the checker
// scores every output beat.
// ----------------------------------------------------------------------------
module hsv_rainbow_to_rgb_unit_tb;
    import hrgb_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int PIPE_SLACK   = 8;        // extra wait after the four-stage pipe drains
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 6;
    localparam int PIXELS_PER_PHASE = 100;

    // Index past the last register; writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    // Register settings per random phase; the last one is drawn at random
    localparam logic       YS_SET [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    localparam logic       GH_SET [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    localparam logic [7:0] GS_SET [PHASES] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd255, 8'd0};

    // Directed pixels, packed as brightness, saturation, hue
    localparam int N_DIRECTED = 24;
    localparam logic [23:0] DIRECTED [N_DIRECTED] = '{
        24'hFFFF00, 24'hFFFF1F, 24'hFFFF20, 24'hFFFF3F, 24'hFFFF40, 24'hFFFF5F,
        24'hFFFF60, 24'hFFFF7F, 24'hFFFF80, 24'hFFFFA0, 24'hFFFFC0, 24'hFFFFE0,
        24'hFFFFFF, 24'hFF0055, 24'hFF0137, 24'hFFFE99, 24'h00FF40, 24'h01FF40,
        24'hFEFFC5, 24'h8080AA, 24'h000000, 24'h0100E3, 24'h7F7F3A, 24'h1001F1
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;   // hue [7:0], saturation [15:8], brightness [23:16]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;          // red [7:0], green [15:8], blue [23:16]

    int pixels_due;
    int mismatch_cnt;
    int cycle_cnt  = 0;
    int burst_left = 1;
    int ready_run  = 0;

    always #6 aclk = ~aclk;

    hsv_rainbow_to_rgb_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    hsv_rainbow_to_rgb_unit_chk u_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .pixels_due   (pixels_due),
        .mismatch_cnt (mismatch_cnt)
    );

    // Output side: alternate ready and stall runs of random length; now and
    // then hold ready for a long stretch so the pipe runs flat out
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_run = 0;
        end else if (ready_run > 0) begin
            ready_run--;
        end else if (m_tready) begin
            m_tready <= 1'b0;
            ready_run = $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
            ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(0, 10);
        end
    end

    always @(posedge aclk)
        cycle_cnt <= cycle_cnt + 1;

    // Watchdog: a hang anywhere ends the run as a failure
    initial begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge aclk);
        $display("** hsv_rainbow_to_rgb_unit: FAILED **");
        $finish;
    end

    // Mostly random levels, with the edge values showing up often
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd254;
            default: return 8'($urandom);
        endcase
    endfunction

    // Present one pixel and hold it until accepted. At the end of a burst,
    // drop valid, scramble the data bus and idle for a random gap.
    task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                              input logic [7:0] bri);
        s_tdata  <= {bri, sat, hue};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Stop sending and wait until every predicted pixel has come out
    task automatic drain_pipe();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        do @(negedge aclk); while (pixels_due != 0);
        repeat (PIPE_SLACK) @(posedge aclk);
    endtask

    // Write all registers back to back, plus a dropped write to the spare
    // index; the 1-bit registers get junk in their upper data bits
    task automatic program_regs(input logic ys, input logic gh, input logic [7:0] gs);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_YELLOW_STRONG;
        cfg_wdata <= {7'($urandom), ys};
        @(posedge aclk);
        cfg_addr  <= CFG_GREEN_HALVE;
        cfg_wdata <= {7'($urandom), gh};
        @(posedge aclk);
        cfg_addr  <= CFG_GREEN_SCALE;
        cfg_wdata <= gs;
        @(posedge aclk);
        cfg_addr  <= CFG_SPARE;
        cfg_wdata <= 8'($urandom);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic       ys;
        logic       gh;
        logic [7:0] gs;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed sweep under reset settings: every hue section, the ramp ends of the
        // first four sections, white, black and the near-edge saturation and brightness
        for (int i = 0; i < N_DIRECTED; i++)
            send_pixel(DIRECTED[i][7:0], DIRECTED[i][15:8], DIRECTED[i][23:16]);
        drain_pipe();

        // Random pixels under each register setting; drain before each rewrite
        for (int p = 0; p < PHASES; p++) begin
            ys = YS_SET[p];
            gh = GH_SET[p];
            gs = GS_SET[p];
            if (p == PHASES - 1) begin
                ys = 1'($urandom);
                gh = 1'($urandom);
                gs = 8'($urandom_range(2, 254));
            end
            program_regs(ys, gh, gs);
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
                send_pixel(8'($urandom), pick_level(), pick_level());
            drain_pipe();
        end

        if (mismatch_cnt == 0) begin
            $display("** hsv_rainbow_to_rgb_unit: PASSED **");
        end else begin
            $display("** hsv_rainbow_to_rgb_unit: FAILED **");
        end
        $finish;
    end

endmodule
